// ===== rtl/hkre_pkg.sv =====
// ----------------------------------------------------------------------------
// hkre_pkg
// Shared types, constants and the key translation table for the boot
// keyboard report to key-state write converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hkre_pkg;

  localparam int ReportKeys      = 6;
  localparam int KeySlotsDefault = 6;
  localparam int ModWrites       = 3;

  localparam logic [7:0] CodeShift = 8'hAE;
  localparam logic [7:0] CodeCtrl  = 8'hAF;
  localparam logic [7:0] CodeAlt   = 8'hB1;

  localparam logic [7:0] ModShiftMask = 8'h22;
  localparam logic [7:0] ModCtrlMask  = 8'h11;
  localparam logic [7:0] ModAltMask   = 8'h44;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } report_t;

  typedef struct packed {
    logic [7:0] state_code;
    logic       state_value;
    logic       last_write;
  } key_write_t;

  // one pending table write
  typedef struct packed {
    logic [7:0] code;
    logic       value;
  } wr_t;

  // what one slot lane found
  typedef struct packed {
    logic       rel_vld;
    logic [7:0] rel_code;
    logic       prs_vld;
    logic [7:0] prs_code;
  } lane_t;

  localparam logic [7:0] XlateRom [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'hC2, 8'hD9, 8'hCE, 8'hCD,
    8'hCC, 8'hD2, 8'hD8, 8'hDD, 8'hE6, 8'hE2, 8'hE7, 8'hEC,
    8'hE3, 8'hDE, 8'hEB, 8'hF0, 8'hC1, 8'hD1, 8'hC7, 8'hD7,
    8'hE1, 8'hD3, 8'hC6, 8'hC8, 8'hDC, 8'hC3, 8'hC0, 8'hC5,
    8'hCB, 8'hD0, 8'hD6, 8'hDB, 8'hE0, 8'hE5, 8'hEA, 8'hEF,
    8'hBD, 8'h71, 8'hBC, 8'hBE, 8'hD4, 8'hF9, 8'hF5, 8'hFA,
    8'hF6, 8'hF7, 8'hBF, 8'hF2, 8'hE8, 8'hBF, 8'hFB, 8'hED,
    8'hF3, 8'h00, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h64,
    8'h65, 8'h66, 8'h67, 8'h68, 8'h71, 8'h72, 8'h7C, 8'h7D,
    8'hB0, 8'h8B, 8'h8A, 8'h8E, 8'h8C, 8'h8D, 8'h8F, 8'hA8,
    8'hA7, 8'hA9, 8'hAA, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h9C,
    8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9D,
    8'h9E, 8'h9F, 8'h92, 8'h94, 8'hF7, 8'hB1, 8'h00, 8'hF5,
    8'h73, 8'h74, 8'h7C, 8'h7D, 8'h80, 8'h81, 8'h82, 8'h83,
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h7D, 8'h7C, 8'h74, 8'h8D,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h8A, 8'h00
  };

  function automatic logic [7:0] xlate(logic [7:0] code);
    if (code[7]) begin
      return 8'h00;
    end
    return XlateRom[code[6:0]];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hkre_lane.sv =====
// ----------------------------------------------------------------------------
// hkre_lane
// One key slot: finds a release of the old key and a press of the new key,
// each translated, against the full old and new slot sets.
// ----------------------------------------------------------------------------
`default_nettype none

module hkre_lane #(
  parameter int UsedSlots = hkre_pkg::KeySlotsDefault
) (
  input  logic [7:0]     old_key_i,
  input  logic [7:0]     new_key_i,
  input  logic [7:0]     old_keys_i [UsedSlots],
  input  logic [7:0]     new_keys_i [UsedSlots],
  output hkre_pkg::lane_t lane_o
);
  import hkre_pkg::*;

  logic       old_in_new;
  logic       new_in_old;
  logic [7:0] rel_x;
  logic [7:0] prs_x;

  always_comb begin
    old_in_new = 1'b0;
    new_in_old = 1'b0;
    for (int i = 0; i < UsedSlots; i++) begin
      if (new_keys_i[i] == old_key_i) old_in_new = 1'b1;
      if (old_keys_i[i] == new_key_i) new_in_old = 1'b1;
    end
  end

  assign rel_x = xlate(old_key_i);
  assign prs_x = xlate(new_key_i);

  assign lane_o.rel_vld  = (old_key_i != 8'h00) && !old_in_new && (rel_x != 8'h00);
  assign lane_o.rel_code = rel_x;
  assign lane_o.prs_vld  = (new_key_i != 8'h00) && !new_in_old && (prs_x != 8'h00);
  assign lane_o.prs_code = prs_x;

endmodule

`default_nettype wire

// ===== rtl/hkre_merge.sv =====
// ----------------------------------------------------------------------------
// hkre_merge
// Merges the lane results of one report into an ordered write stream, one
// write per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hkre_merge #(
  parameter int NumWrites = hkre_pkg::ModWrites + 2 * hkre_pkg::KeySlotsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_vld_i,
  input  logic [NumWrites-1:0]   job_mask_i,
  input  hkre_pkg::wr_t          job_wr_i [NumWrites],
  output logic                   job_take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hkre_pkg::key_write_t   out_data_o
);
  import hkre_pkg::*;

  localparam int IdxW = $clog2(NumWrites);

  logic [NumWrites-1:0] mask_q, mask_d;
  wr_t                  wr_q [NumWrites];
  logic                 out_vld_q, out_vld_d;
  key_write_t           out_q, out_d;

  logic [NumWrites-1:0] low;
  logic [NumWrites-1:0] rest;
  logic [IdxW-1:0]      sel;
  logic                 busy;
  logic                 advance;
  logic                 last_now;

  assign busy     = |mask_q;
  assign low      = mask_q & (~mask_q + NumWrites'(1));
  assign rest     = mask_q & ~low;
  assign last_now = busy && (rest == '0);
  assign advance  = !out_vld_q || !out_stall_i;

  always_comb begin
    sel = '0;
    for (int i = NumWrites - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = IdxW'(i);
    end
  end

  assign job_take_o = job_vld_i && advance && (!busy || last_now);

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mask_d    = mask_q;
    if (advance) begin
      out_vld_d         = busy;
      out_d.state_code  = wr_q[sel].code;
      out_d.state_value = wr_q[sel].value;
      out_d.last_write  = last_now;
      mask_d            = job_take_o ? job_mask_i : rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (job_take_o) begin
      wr_q <= job_wr_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_take_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_o |-> (!busy || last_now))
    else $error("job loaded while writes still pending");

  a_pending_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && advance |=> out_vld_q)
    else $error("pending write not presented");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && advance && !busy |=> !out_vld_q)
    else $error("write presented with nothing pending");

endmodule

`default_nettype wire

// ===== rtl/hid_keyboard_report_to_key_events_core.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_core
// Boot keyboard report to ordered key-state table writes.
//
// Input channel: one report (modifier byte, six key slots) per transaction.
// Output channel: one key-state write per transaction: three modifier writes
// (shift, ctrl, alt), then per slot a release of a vanished key and a press
// of a new key; last_write marks the final write of a report.
// With the core idle, an accepted report passes the job register and the
// merge pending registers before its first write sits in the output register.
// Throughput: one write per cycle from the merge serializer while the receiver
// does not stall; a report causes 3 to 3 + 2*min(KEY_SLOTS,6) writes, and the
// next report is compared and queued while the current one drains.
// Reset clears the remembered key slots to empty and drops pending writes.
// When the receiver stalls, the current write holds and the serializer and
// then the input channel stall behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_to_key_events_core #(
  parameter int KEY_SLOTS = hkre_pkg::KeySlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hkre_pkg::report_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hkre_pkg::key_write_t out_data_o
);
  import hkre_pkg::*;

  localparam int UsedSlots = (KEY_SLOTS < ReportKeys) ? KEY_SLOTS : ReportKeys;
  localparam int NumWrites = ModWrites + 2 * UsedSlots;

  logic [7:0]           now_keys [ReportKeys];
  logic [7:0]           new_keys [UsedSlots];
  logic [7:0]           prev_q   [UsedSlots];
  lane_t                lanes    [UsedSlots];

  logic                 job_vld_q, job_vld_d;
  logic [NumWrites-1:0] job_mask_q, job_mask_d;
  wr_t                  job_wr_q [NumWrites];
  wr_t                  job_wr_d [NumWrites];
  logic                 job_take;
  logic                 accept;

  assign now_keys[0] = in_data_i.key_0;
  assign now_keys[1] = in_data_i.key_1;
  assign now_keys[2] = in_data_i.key_2;
  assign now_keys[3] = in_data_i.key_3;
  assign now_keys[4] = in_data_i.key_4;
  assign now_keys[5] = in_data_i.key_5;

  for (genvar g = 0; g < UsedSlots; g++) begin : g_lane
    assign new_keys[g] = now_keys[g];

    hkre_lane #(.UsedSlots(UsedSlots)) u_lane (
      .old_key_i  (prev_q[g]),
      .new_key_i  (new_keys[g]),
      .old_keys_i (prev_q),
      .new_keys_i (new_keys),
      .lane_o     (lanes[g])
    );
  end

  assign in_stall_o = job_vld_q && !job_take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    job_mask_d     = '0;
    job_mask_d[0]  = 1'b1;
    job_mask_d[1]  = 1'b1;
    job_mask_d[2]  = 1'b1;
    job_wr_d[0].code  = CodeShift;
    job_wr_d[0].value = |(in_data_i.modifiers & ModShiftMask);
    job_wr_d[1].code  = CodeCtrl;
    job_wr_d[1].value = |(in_data_i.modifiers & ModCtrlMask);
    job_wr_d[2].code  = CodeAlt;
    job_wr_d[2].value = |(in_data_i.modifiers & ModAltMask);
    for (int i = 0; i < UsedSlots; i++) begin
      job_mask_d[ModWrites + 2*i]         = lanes[i].rel_vld;
      job_wr_d[ModWrites + 2*i].code      = lanes[i].rel_code;
      job_wr_d[ModWrites + 2*i].value     = 1'b0;
      job_mask_d[ModWrites + 2*i + 1]     = lanes[i].prs_vld;
      job_wr_d[ModWrites + 2*i + 1].code  = lanes[i].prs_code;
      job_wr_d[ModWrites + 2*i + 1].value = 1'b1;
    end
  end

  always_comb begin
    job_vld_d = job_vld_q;
    if (accept) begin
      job_vld_d = 1'b1;
    end else if (job_take) begin
      job_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      for (int i = 0; i < UsedSlots; i++) begin
        prev_q[i] <= 8'h00;
      end
    end else begin
      job_vld_q <= job_vld_d;
      if (accept) begin
        prev_q <= new_keys;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_mask_q <= job_mask_d;
      job_wr_q   <= job_wr_d;
    end
  end

  hkre_merge #(.NumWrites(NumWrites)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (job_vld_q),
    .job_mask_i  (job_mask_q),
    .job_wr_i    (job_wr_q),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_accept_queues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> job_vld_q)
    else $error("accepted report not queued");

  a_mods_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> (job_mask_q[0] && job_mask_q[1] && job_mask_q[2]))
    else $error("queued report lacks modifier writes");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> job_vld_q && !job_take)
    else $error("input stalled with free job slot");

endmodule

`default_nettype wire

// ===== tb/sv/tb_hid_keyboard_report_to_key_events_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_to_key_events_core
// Sends boot keyboard reports through the core and checks each key-state
// write against a local model of the slot compare: three modifier writes,
// then per slot a release of a vanished key and a press of a new one.
// Covers directed corner reports, random typing sequences with noise, and
// phases with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_to_key_events_core;
  import hkre_pkg::*;

  typedef logic [7:0] slot_arr_t [6];

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 8;

  localparam logic [7:0] UsageToScan [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'hC2, 8'hD9, 8'hCE, 8'hCD,
    8'hCC, 8'hD2, 8'hD8, 8'hDD, 8'hE6, 8'hE2, 8'hE7, 8'hEC,
    8'hE3, 8'hDE, 8'hEB, 8'hF0, 8'hC1, 8'hD1, 8'hC7, 8'hD7,
    8'hE1, 8'hD3, 8'hC6, 8'hC8, 8'hDC, 8'hC3, 8'hC0, 8'hC5,
    8'hCB, 8'hD0, 8'hD6, 8'hDB, 8'hE0, 8'hE5, 8'hEA, 8'hEF,
    8'hBD, 8'h71, 8'hBC, 8'hBE, 8'hD4, 8'hF9, 8'hF5, 8'hFA,
    8'hF6, 8'hF7, 8'hBF, 8'hF2, 8'hE8, 8'hBF, 8'hFB, 8'hED,
    8'hF3, 8'h00, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h64,
    8'h65, 8'h66, 8'h67, 8'h68, 8'h71, 8'h72, 8'h7C, 8'h7D,
    8'hB0, 8'h8B, 8'h8A, 8'h8E, 8'h8C, 8'h8D, 8'h8F, 8'hA8,
    8'hA7, 8'hA9, 8'hAA, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h9C,
    8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9D,
    8'h9E, 8'h9F, 8'h92, 8'h94, 8'hF7, 8'hB1, 8'h00, 8'hF5,
    8'h73, 8'h74, 8'h7C, 8'h7D, 8'h80, 8'h81, 8'h82, 8'h83,
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h7D, 8'h7C, 8'h74, 8'h8D,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h8A, 8'h00
  };

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  report_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  key_write_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  slot_arr_t  held_keys = '{default: 8'h00};
  key_write_t pending_writes[$];
  report_t    last_sent = '0;

  hid_keyboard_report_to_key_events_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] usage_to_scan(logic [7:0] usage);
    if (usage[7]) begin
      return 8'h00;
    end
    return UsageToScan[usage[6:0]];
  endfunction

  function automatic bit slot_holds(slot_arr_t slots, logic [7:0] usage);
    foreach (slots[i]) begin
      if (slots[i] == usage) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic slot_arr_t slots_of(report_t r);
    slot_arr_t s;
    s = '{r.key_0, r.key_1, r.key_2, r.key_3, r.key_4, r.key_5};
    return s;
  endfunction

  function automatic report_t report_of(logic [7:0] mods, slot_arr_t s);
    return report_t'{mods, s[0], s[1], s[2], s[3], s[4], s[5]};
  endfunction

  function automatic key_write_t key_write(logic [7:0] code, logic value);
    return key_write_t'{code, value, 1'b0};
  endfunction

  // expected writes for one accepted report; updates the held slots
  function automatic void predict_key_writes(report_t r);
    slot_arr_t  now_keys;
    key_write_t batch[$];
    logic [7:0] scan;
    now_keys = slots_of(r);
    batch.push_back(key_write(CodeShift, |(r.modifiers & ModShiftMask)));
    batch.push_back(key_write(CodeCtrl, |(r.modifiers & ModCtrlMask)));
    batch.push_back(key_write(CodeAlt, |(r.modifiers & ModAltMask)));
    for (int i = 0; i < 6; i++) begin
      if (held_keys[i] != 8'h00 && !slot_holds(now_keys, held_keys[i])) begin
        scan = usage_to_scan(held_keys[i]);
        if (scan != 8'h00) begin
          batch.push_back(key_write(scan, 1'b0));
        end
      end
      if (now_keys[i] != 8'h00 && !slot_holds(held_keys, now_keys[i])) begin
        scan = usage_to_scan(now_keys[i]);
        if (scan != 8'h00) begin
          batch.push_back(key_write(scan, 1'b1));
        end
      end
    end
    batch[batch.size() - 1].last_write = 1'b1;
    foreach (batch[i]) begin
      pending_writes.push_back(batch[i]);
    end
    held_keys = now_keys;
  endfunction

  // typing-like report derived from the previous one, with some noise
  function automatic report_t gen_typing_report();
    slot_arr_t   s;
    logic [7:0]  mods;
    int unsigned pick;
    logic [7:0]  first;
    if ($urandom_range(99) < 12) begin
      return report_t'($urandom()) ^ (report_t'($urandom()) << 32);
    end
    s = slots_of(last_sent);
    mods = ($urandom_range(99) < 60) ? last_sent.modifiers : 8'($urandom_range(255));
    if ($urandom_range(99) < 10) begin
      first = s[0];
      for (int i = 0; i < 5; i++) begin
        s[i] = s[i + 1];
      end
      s[5] = first;
    end
    for (int i = 0; i < 6; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        s[i] = s[i];
      end else if (pick < 72) begin
        s[i] = 8'h00;
      end else if (pick < 90) begin
        s[i] = 8'($urandom_range(8'h04, 8'h65));
      end else if (pick < 95) begin
        s[i] = s[$urandom_range(5)];
      end else begin
        s[i] = 8'($urandom_range(255));
      end
    end
    return report_of(mods, s);
  endfunction

  task automatic send_report(input report_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predict_key_writes(r);
    last_sent = r;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic reset_dut();
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed();
    report_t dir_q[$];
    dir_q.push_back(report_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h20, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00});
    // key moves slot, other released
    dir_q.push_back(report_t'{8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h10, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    // codes with zero translation: no writes, but still remembered
    dir_q.push_back(report_t'{8'h40, 8'h80, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h39});
    dir_q.push_back(report_t'{8'h40, 8'hFF, 8'h80, 8'h39, 8'h03, 8'h02, 8'h01});
    dir_q.push_back(report_t'{8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h08, 8'h7F, 8'h66, 8'h7E, 8'h65, 8'h29, 8'h78});
    dir_q.push_back(report_t'{8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
    // full swap: six releases and six presses
    dir_q.push_back(report_t'{8'h77, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F});
    // duplicates
    dir_q.push_back(report_t'{8'h80, 8'h1E, 8'h1E, 8'h1E, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h22, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h11, 8'h28, 8'h28, 8'h64, 8'h64, 8'h2A, 8'h2A});
    dir_q.push_back(report_t'{8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    dir_q.push_back(report_t'{8'h55, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    dir_q.push_back(report_t'{8'hAA, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F});
    dir_q.push_back(report_t'{8'h00, 8'h3A, 8'h45, 8'h4F, 8'h52, 8'h68, 8'h73});
    dir_q.push_back(report_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    dir_q.push_back(report_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    foreach (dir_q[i]) begin
      send_report(dir_q[i]);
    end
  endtask

  task automatic test_typing_random(input int count, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      send_report(gen_typing_report());
    end
  endtask

  // sender holds off until the core has emitted everything owed
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_report(gen_typing_report());
    end
    wait_drained();
    send_report(gen_typing_report());
  endtask

  always @(posedge clk) begin
    key_write_t exp_w;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: code %h value %b last %b", $time,
                 out_data.state_code, out_data.state_value, out_data.last_write);
        error_count++;
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_data.state_code !== exp_w.state_code ||
            out_data.state_value !== exp_w.state_value ||
            out_data.last_write !== exp_w.last_write) begin
          $display("%0t: mismatch: expected code %h value %b last %b, got code %h value %b last %b",
                   $time, exp_w.state_code, exp_w.state_value, exp_w.last_write,
                   out_data.state_code, out_data.state_value, out_data.last_write);
          error_count++;
        end
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_dut();
    test_directed();
    wait_drained();
    test_typing_random(60, 0, 0);
    test_drain_pause();
    test_typing_random(60, 79, 0);
    test_typing_random(60, 0, 79);
    test_drain_pause();
    test_typing_random(60, 38, 38);
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && pending_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
